@@ src/mxs_pkg.sv @@
// ----------------------------------------------------------------------------
// mxs_pkg: shared types and constants for the max-XOR set engine
// Operation and status codes, count limits and the flag bundle that
// travels with a transaction through the chain of entry cells.
// ----------------------------------------------------------------------------
package mxs_pkg;

  // Port widths fixed by the interface
  localparam int unsigned DATA_W = 32;
  localparam int unsigned MODE_W = 2;
  localparam int unsigned STATUS_W = 2;

  // Copy count per entry
  localparam int unsigned COUNT_W = 7;
  localparam logic [COUNT_W-1:0] COUNT_MAX = 7'd127;

  // Parameter defaults
  localparam int unsigned KEY_BITS_DEF = 32;
  localparam int unsigned CAPACITY_DEF = 64;

  // Operation codes (code 3 is unused and does nothing)
  typedef logic [MODE_W-1:0] mode_t;
  localparam mode_t MODE_INSERT = 2'd0;
  localparam mode_t MODE_DELETE = 2'd1;
  localparam mode_t MODE_QUERY  = 2'd2;

  // Status codes
  typedef logic [STATUS_W-1:0] status_t;
  localparam status_t ST_OK     = 2'd0;
  localparam status_t ST_EMPTY  = 2'd1;
  localparam status_t ST_ABSENT = 2'd2;
  localparam status_t ST_FULL   = 2'd3;

  // Control flags carried by a transaction from cell to cell
  typedef struct packed {
    logic  valid;    // token present at this stage
    mode_t mode;     // operation
    logic  found;    // a nonempty cell holds the key
    logic  claimed;  // a free cell has been reserved for an insert
    logic  any;      // at least one nonempty cell seen
    logic  sat;      // matching cell count already at maximum
  } tok_flags_t;

  // End-of-pass broadcast that settles a reserved cell
  typedef struct packed {
    logic fire;  // transaction leaves the chain
    logic keep;  // reserved cell becomes a live entry
  } commit_t;

endpackage

@@ src/mxs_cell.sv @@
// ----------------------------------------------------------------------------
// mxs_cell: one entry cell of the max-XOR set chain
// Holds one key and its copy count, applies the passing transaction to
// its own entry and hands the updated token to the next cell.
// ----------------------------------------------------------------------------
module mxs_cell #(
  parameter int unsigned KW = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  mxs_pkg::tok_flags_t  flags_i,
  input  logic [KW-1:0]        key_i,
  input  logic [KW-1:0]        max_i,
  input  mxs_pkg::commit_t     commit_i,
  output mxs_pkg::tok_flags_t  flags_o,
  output logic [KW-1:0]        key_o,
  output logic [KW-1:0]        max_o
);

  logic [mxs_pkg::COUNT_W-1:0] count_q, count_d;
  logic [KW-1:0]               value_q;
  logic                        pending_q, pending_d;
  logic                        load_value;
  logic                        is_free;
  logic                        hit;
  logic [KW-1:0]               xor_val;
  mxs_pkg::tok_flags_t         flags_q, flags_d;
  logic [KW-1:0]               key_q;
  logic [KW-1:0]               max_q, max_d;

  assign is_free = (count_q == '0);
  assign hit     = !is_free && (value_q == key_i);
  assign xor_val = key_i ^ value_q;

  // Apply the transaction to this entry and update the token
  always_comb begin
    flags_d    = flags_i;
    max_d      = max_i;
    count_d    = count_q;
    pending_d  = pending_q;
    load_value = 1'b0;
    if (flags_i.valid) begin
      flags_d.found = flags_i.found | hit;
      flags_d.any   = flags_i.any | !is_free;
      unique case (flags_i.mode)
        mxs_pkg::MODE_INSERT: begin
          if (hit) begin
            if (count_q == mxs_pkg::COUNT_MAX) begin
              flags_d.sat = 1'b1;
            end else begin
              count_d = count_q + mxs_pkg::COUNT_W'(1);
            end
          end else if (is_free && !flags_i.claimed) begin
            flags_d.claimed = 1'b1;
            load_value      = 1'b1;
            pending_d       = 1'b1;
          end
        end
        mxs_pkg::MODE_DELETE: begin
          if (hit) begin
            count_d = count_q - mxs_pkg::COUNT_W'(1);
          end
        end
        mxs_pkg::MODE_QUERY: begin
          if (!is_free && (xor_val > max_i)) begin
            max_d = xor_val;
          end
        end
        default: begin
        end
      endcase
    end
    // Settle a reserved entry once the whole chain has been searched
    if (commit_i.fire && pending_q) begin
      pending_d = 1'b0;
      if (commit_i.keep) begin
        count_d = mxs_pkg::COUNT_W'(1);
      end
    end
  end

  // Entry state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      pending_q <= 1'b0;
      flags_q   <= '0;
    end else begin
      count_q   <= count_d;
      pending_q <= pending_d;
      flags_q   <= flags_d;
    end
  end

  // Payload: key storage and token data, no reset
  always_ff @(posedge clk_i) begin
    if (load_value) begin
      value_q <= key_i;
    end
    key_q <= key_i;
    max_q <= max_d;
  end

  assign flags_o = flags_q;
  assign key_o   = key_q;
  assign max_o   = max_q;

endmodule

@@ src/max_xor_set_engine_top.sv @@
// ----------------------------------------------------------------------------
// max_xor_set_engine_top: multiset of keys with a max-XOR query
// Keeps up to CAPACITY distinct keys with copy counts in a chain of entry
// cells and answers insert, delete and max-XOR query transactions.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries mode_i and key_value_i.
//   Output channel (out_valid_o / out_stall_i) carries xor_result_o and
//   status_o, exactly one result per input transaction, in order.
//   A transaction walks the cell chain one cell per cycle; each cell checks
//   and updates its own entry. After the last cell, the result settles a
//   reserved free cell (new key on insert) and moves to the output register.
//   The block takes one transaction at a time: in_stall_o stays high
//   while a transaction is in the chain or waits at the end of it.
//   The output register holds a finished result while the next transaction
//   is taken and walks the chain. If out_stall_i keeps the output register
//   full, the following result waits at the chain end and input stays
//   stalled.
//   Reset clears all copy counts, so the set starts empty; no clearing
//   pass is needed and input is taken in the first cycle after reset.
// ----------------------------------------------------------------------------
module max_xor_set_engine_top #(
  parameter int unsigned KEY_BITS = mxs_pkg::KEY_BITS_DEF,
  parameter int unsigned CAPACITY = mxs_pkg::CAPACITY_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [mxs_pkg::MODE_W-1:0]    mode_i,
  input  logic [mxs_pkg::DATA_W-1:0]    key_value_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [mxs_pkg::DATA_W-1:0]    xor_result_o,
  output logic [mxs_pkg::STATUS_W-1:0]  status_o
);

  // Stored key width: keys are masked to KEY_BITS and the port has 32 bits
  localparam int unsigned KW = (KEY_BITS < mxs_pkg::DATA_W) ? KEY_BITS : mxs_pkg::DATA_W;

  mxs_pkg::tok_flags_t chain_flags [CAPACITY+1];
  logic [KW-1:0]       chain_key   [CAPACITY+1];
  logic [KW-1:0]       chain_max   [CAPACITY+1];
  logic [CAPACITY-1:0] stage_valid;

  logic                            busy_q;
  logic                            accept;
  logic                            finish;
  mxs_pkg::commit_t                commit;
  mxs_pkg::tok_flags_t             done_flags_q;
  logic [KW-1:0]                   done_max_q;
  logic                            out_valid_q;
  logic [mxs_pkg::DATA_W-1:0]      out_xor_q, out_xor_d;
  mxs_pkg::status_t                out_status_q, out_status_d;

  assign accept = in_valid_i && !busy_q;
  assign finish = done_flags_q.valid && (!out_valid_q || !out_stall_i);

  // Launch a new token into the head of the chain
  always_comb begin
    chain_flags[0]       = '0;
    chain_flags[0].valid = accept;
    chain_flags[0].mode  = mode_i;
    chain_key[0]         = key_value_i[KW-1:0];
    chain_max[0]         = '0;
  end

  // Settle the reserved cell of a new insert
  always_comb begin
    commit.fire = finish;
    commit.keep = (done_flags_q.mode == mxs_pkg::MODE_INSERT) &&
                  !done_flags_q.found && done_flags_q.claimed;
  end

  // Chain of entry cells
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    mxs_cell #(
      .KW (KW)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .flags_i  (chain_flags[g]),
      .key_i    (chain_key[g]),
      .max_i    (chain_max[g]),
      .commit_i (commit),
      .flags_o  (chain_flags[g+1]),
      .key_o    (chain_key[g+1]),
      .max_o    (chain_max[g+1])
    );
    assign stage_valid[g] = chain_flags[g+1].valid;
  end

  // Form the result from the finished token
  always_comb begin
    out_xor_d         = '0;
    out_xor_d[KW-1:0] = done_max_q;
    out_status_d      = mxs_pkg::ST_OK;
    unique case (done_flags_q.mode)
      mxs_pkg::MODE_INSERT: begin
        if (done_flags_q.found) begin
          out_status_d = done_flags_q.sat ? mxs_pkg::ST_FULL : mxs_pkg::ST_OK;
        end else begin
          out_status_d = done_flags_q.claimed ? mxs_pkg::ST_OK : mxs_pkg::ST_FULL;
        end
      end
      mxs_pkg::MODE_DELETE: begin
        out_status_d = done_flags_q.found ? mxs_pkg::ST_OK : mxs_pkg::ST_ABSENT;
      end
      mxs_pkg::MODE_QUERY: begin
        out_status_d = done_flags_q.any ? mxs_pkg::ST_OK : mxs_pkg::ST_EMPTY;
      end
      default: begin
        out_status_d = mxs_pkg::ST_OK;
      end
    endcase
  end

  // Busy flag, chain tail and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q       <= 1'b0;
      done_flags_q <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (accept) begin
        busy_q <= 1'b1;
      end else if (finish) begin
        busy_q <= 1'b0;
      end
      if (chain_flags[CAPACITY].valid) begin
        done_flags_q <= chain_flags[CAPACITY];
      end else if (finish) begin
        done_flags_q.valid <= 1'b0;
      end
      if (finish) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (chain_flags[CAPACITY].valid) begin
      done_max_q <= chain_max[CAPACITY];
    end
    if (finish) begin
      out_xor_q    <= out_xor_d;
      out_status_q <= out_status_d;
    end
  end

  assign in_stall_o   = busy_q;
  assign out_valid_o  = out_valid_q;
  assign xor_result_o = out_xor_q;
  assign status_o     = out_status_q;

  // At most one transaction in flight through the chain and its tail
  a_single_token : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($countones({stage_valid, done_flags_q.valid}) <= 1))
    else $error("more than one transaction in the cell chain");

  // Idle block has an empty chain
  a_idle_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_q |-> (stage_valid == '0 && !done_flags_q.valid))
    else $error("chain holds a token while the block is idle");

  // A new result appears only when a finished token was waiting
  a_result_source : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(done_flags_q.valid))
    else $error("result raised without a finished transaction");

  // Finishing a transaction frees the input side
  a_finish_frees : assert property (@(posedge clk_i) disable iff (!rst_ni)
    finish |=> !busy_q)
    else $error("input still stalled after a transaction finished");

endmodule

@@ tb/sv/max_xor_set_engine_top_tb.sv @@
// ----------------------------------------------------------------------------
// max_xor_set_engine_top_tb: self-checking bench for the max-XOR set engine
// Drives insert, delete and query transactions through the valid/stall
// input channel. A local model of the key multiset predicts each result.
// A directed table covers the extremes, every operation and the empty and absent codes.
// Structured random phases then mix traffic on a small key pool, fill the
// store, saturate a copy count and drain the set. Random gaps and stalls
// fall on both channels.
// ----------------------------------------------------------------------------
module max_xor_set_engine_top_tb;

  localparam int unsigned KEY_BITS = mxs_pkg::KEY_BITS_DEF;
  localparam int unsigned CAPACITY = mxs_pkg::CAPACITY_DEF;
  localparam logic [mxs_pkg::DATA_W-1:0] KEY_MASK =
    (KEY_BITS >= mxs_pkg::DATA_W) ? '1 : ((mxs_pkg::DATA_W'(1) << KEY_BITS) - 1'b1);
  localparam mxs_pkg::mode_t MODE_UNUSED = 2'd3;

  localparam int ITEM_TARGET    = 800;
  localparam int POOL_SIZE      = 12;
  localparam int HOLD_CYCLES    = 400;
  localparam int DRAIN_CYCLES   = CAPACITY + 2 + 8;
  localparam int WATCHDOG_LIMIT = 4000;

  // One expected result
  typedef struct packed {
    logic [mxs_pkg::DATA_W-1:0] xor_val;
    mxs_pkg::status_t           st;
  } set_reply_t;

  // One directed row; known marks a result typed in by hand
  typedef struct packed {
    mxs_pkg::mode_t             op;
    logic [mxs_pkg::DATA_W-1:0] key;
    logic                       known;
    logic [mxs_pkg::DATA_W-1:0] xor_val;
    mxs_pkg::status_t           st;
  } op_row_t;

  localparam int DIR_ROWS = 25;
  localparam op_row_t DIRECTED [DIR_ROWS] = '{
    '{mxs_pkg::MODE_QUERY,  32'h0000_0000, 1'b1, 32'h0000_0000, mxs_pkg::ST_EMPTY},
    '{mxs_pkg::MODE_DELETE, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000, mxs_pkg::ST_ABSENT},
    '{MODE_UNUSED,          32'hFFFF_FFFF, 1'b1, 32'h0000_0000, mxs_pkg::ST_OK},
    '{MODE_UNUSED,          32'h0000_0000, 1'b1, 32'h0000_0000, mxs_pkg::ST_OK},
    '{mxs_pkg::MODE_INSERT, 32'h0000_0000, 1'b1, 32'h0000_0000, mxs_pkg::ST_OK},
    '{mxs_pkg::MODE_QUERY,  32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, mxs_pkg::ST_OK},
    '{mxs_pkg::MODE_INSERT, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000, mxs_pkg::ST_OK},
    '{mxs_pkg::MODE_QUERY,  32'h0000_0000, 1'b1, 32'hFFFF_FFFF, mxs_pkg::ST_OK},
    '{mxs_pkg::MODE_QUERY,  32'h0000_FFFF, 1'b0, 32'h0000_0000, mxs_pkg::ST_OK},
    '{mxs_pkg::MODE_INSERT, 32'h0000_0000, 1'b1, 32'h0000_0000, mxs_pkg::ST_OK},
    '{mxs_pkg::MODE_DELETE, 32'h0000_0000, 1'b1, 32'h0000_0000, mxs_pkg::ST_OK},
    '{mxs_pkg::MODE_DELETE, 32'h0000_0000, 1'b1, 32'h0000_0000, mxs_pkg::ST_OK},
    '{mxs_pkg::MODE_DELETE, 32'h0000_0000, 1'b1, 32'h0000_0000, mxs_pkg::ST_ABSENT},
    '{mxs_pkg::MODE_QUERY,  32'hFFFF_FFFF, 1'b1, 32'h0000_0000, mxs_pkg::ST_OK},
    '{mxs_pkg::MODE_INSERT, 32'h8000_0000, 1'b0, 32'h0000_0000, mxs_pkg::ST_OK},
    '{mxs_pkg::MODE_INSERT, 32'h8000_0000, 1'b0, 32'h0000_0000, mxs_pkg::ST_OK},
    '{mxs_pkg::MODE_QUERY,  32'h7FFF_FFFF, 1'b0, 32'h0000_0000, mxs_pkg::ST_OK},
    '{mxs_pkg::MODE_INSERT, 32'h0000_0001, 1'b0, 32'h0000_0000, mxs_pkg::ST_OK},
    '{mxs_pkg::MODE_QUERY,  32'hA5A5_A5A5, 1'b0, 32'h0000_0000, mxs_pkg::ST_OK},
    '{mxs_pkg::MODE_DELETE, 32'h8000_0000, 1'b0, 32'h0000_0000, mxs_pkg::ST_OK},
    '{mxs_pkg::MODE_DELETE, 32'hFFFF_FFFF, 1'b0, 32'h0000_0000, mxs_pkg::ST_OK},
    '{mxs_pkg::MODE_DELETE, 32'h8000_0000, 1'b0, 32'h0000_0000, mxs_pkg::ST_OK},
    '{mxs_pkg::MODE_DELETE, 32'h0000_0001, 1'b0, 32'h0000_0000, mxs_pkg::ST_OK},
    '{mxs_pkg::MODE_QUERY,  32'h5A5A_5A5A, 1'b1, 32'h0000_0000, mxs_pkg::ST_EMPTY},
    '{mxs_pkg::MODE_QUERY,  32'hFFFF_FFFF, 1'b1, 32'h0000_0000, mxs_pkg::ST_EMPTY}
  };

  logic                         clk_i;
  logic                         rst_ni;
  logic                         in_valid_i;
  logic                         in_stall_o;
  logic [mxs_pkg::MODE_W-1:0]   mode_i;
  logic [mxs_pkg::DATA_W-1:0]   key_value_i;
  logic                         out_valid_o;
  logic                         out_stall_i;
  logic [mxs_pkg::DATA_W-1:0]   xor_result_o;
  logic [mxs_pkg::STATUS_W-1:0] status_o;

  // Local copy of the key multiset
  logic [mxs_pkg::DATA_W-1:0]  set_vals [CAPACITY];
  logic [mxs_pkg::COUNT_W-1:0] set_cnts [CAPACITY];
  int unsigned                 set_live;

  set_reply_t                  pending_results [$];
  logic [mxs_pkg::DATA_W-1:0]  key_pool [POOL_SIZE];
  int                          error_cnt;
  int                          sent_cnt;
  int                          idle_cycles;
  bit                          idle_en;
  bit                          hold_req;

  max_xor_set_engine_top #(
    .KEY_BITS (KEY_BITS),
    .CAPACITY (CAPACITY)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .mode_i       (mode_i),
    .key_value_i  (key_value_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .xor_result_o (xor_result_o),
    .status_o     (status_o)
  );

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Slot of the live entry holding key, or -1
  function automatic int find_key_slot(input logic [mxs_pkg::DATA_W-1:0] key);
    for (int i = 0; i < CAPACITY; i++) begin
      if (set_cnts[i] != '0 && set_vals[i] == key) return i;
    end
    return -1;
  endfunction

  // Apply one operation to the local multiset and return its result
  function automatic set_reply_t apply_set_op(input mxs_pkg::mode_t op,
                                              input logic [mxs_pkg::DATA_W-1:0] key_in);
    set_reply_t                 rep;
    logic [mxs_pkg::DATA_W-1:0] key;
    logic [mxs_pkg::DATA_W-1:0] x;
    int                         slot;
    rep  = '0;
    rep.st = mxs_pkg::ST_OK;
    key  = key_in & KEY_MASK;
    slot = find_key_slot(key);
    case (op)
      mxs_pkg::MODE_INSERT: begin
        if (slot >= 0) begin
          if (set_cnts[slot] == mxs_pkg::COUNT_MAX) rep.st = mxs_pkg::ST_FULL;
          else set_cnts[slot] = set_cnts[slot] + 1'b1;
        end else begin
          for (int i = 0; i < CAPACITY; i++) begin
            if (set_cnts[i] == '0) begin
              slot = i;
              break;
            end
          end
          if (slot < 0) begin
            rep.st = mxs_pkg::ST_FULL;
          end else begin
            set_vals[slot] = key;
            set_cnts[slot] = mxs_pkg::COUNT_W'(1);
            set_live++;
          end
        end
      end
      mxs_pkg::MODE_DELETE: begin
        if (slot < 0) begin
          rep.st = mxs_pkg::ST_ABSENT;
        end else begin
          set_cnts[slot] = set_cnts[slot] - 1'b1;
          if (set_cnts[slot] == '0) set_live--;
        end
      end
      mxs_pkg::MODE_QUERY: begin
        if (set_live == 0) begin
          rep.st = mxs_pkg::ST_EMPTY;
        end else begin
          for (int i = 0; i < CAPACITY; i++) begin
            if (set_cnts[i] != '0) begin
              x = (key ^ set_vals[i]) & KEY_MASK;
              if (x > rep.xor_val) rep.xor_val = x;
            end
          end
        end
      end
      default: ;
    endcase
    return rep;
  endfunction

  // Gap length: mostly short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 4);
    if (r < 93) return $urandom_range(5, 20);
    return $urandom_range(40, 200);
  endfunction

  // Offer one transaction, record its expected result once accepted
  task automatic send_op(input mxs_pkg::mode_t op, input logic [mxs_pkg::DATA_W-1:0] key,
                         input bit known = 1'b0,
                         input logic [mxs_pkg::DATA_W-1:0] kxor = '0,
                         input mxs_pkg::status_t kst = mxs_pkg::ST_OK);
    set_reply_t rep;
    int         gap;
    @(negedge clk_i);
    in_valid_i  <= 1'b1;
    mode_i      <= op;
    key_value_i <= key;
    do @(posedge clk_i); while (in_stall_o);
    rep = apply_set_op(op, key);
    if (known) begin
      rep.xor_val = kxor;
      rep.st      = kst;
    end
    pending_results.push_back(rep);
    sent_cnt++;
    // Insert an idle gap on the input side
    if (idle_en && $urandom_range(0, 99) < 30) begin
      gap = pick_gap();
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
  endtask

  // Stop offering and wait until every expected result has arrived
  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic refill_pool();
    foreach (key_pool[i]) key_pool[i] = $urandom;
  endtask

  // Random traffic on the key pool with some noise
  task automatic run_mixed(input int n);
    mxs_pkg::mode_t             op;
    logic [mxs_pkg::DATA_W-1:0] key;
    int                         r;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(0, 99);
      if (r < 70) key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
      else if (r < 75) key = $urandom_range(0, 1) ? '1 : '0;
      else key = $urandom;
      r = $urandom_range(0, 99);
      if (r < 40) op = mxs_pkg::MODE_INSERT;
      else if (r < 65) op = mxs_pkg::MODE_DELETE;
      else if (r < 95) op = mxs_pkg::MODE_QUERY;
      else op = MODE_UNUSED;
      send_op(op, key);
    end
  endtask

  // Receiver stall: random stretches, plus one long hold on request
  initial begin
    int stall_left;
    stall_left  = 0;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_req = 1'b0;
        out_stall_i <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
        if (idle_en && $urandom_range(0, 99) < 15) stall_left = pick_gap();
      end
    end
  end

  // Check each result transaction against the oldest expectation
  always @(posedge clk_i) begin
    set_reply_t exp_rep;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: xor_result=%h status=%0d", xor_result_o, status_o);
        error_cnt++;
      end else begin
        exp_rep = pending_results.pop_front();
        if (xor_result_o !== exp_rep.xor_val) begin
          $error("xor_result: expected %h, actual %h", exp_rep.xor_val, xor_result_o);
          error_cnt++;
        end
        if (status_o !== exp_rep.st) begin
          $error("status: expected %0d, actual %0d", exp_rep.st, status_o);
          error_cnt++;
        end
      end
    end
  end

  // Watchdog: end the run when no transaction moves for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Stimulus sequence
  initial begin
    int slot;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    mode_i      = mxs_pkg::MODE_INSERT;
    key_value_i = '0;
    idle_cycles = 0;
    error_cnt   = 0;
    sent_cnt    = 0;
    idle_en     = 1'b0;
    hold_req    = 1'b0;
    set_live    = 0;
    foreach (set_cnts[i]) begin
      set_cnts[i] = '0;
      set_vals[i] = '0;
    end
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Walk the directed table back to back
    for (int i = 0; i < DIR_ROWS; i++) begin
      send_op(DIRECTED[i].op, DIRECTED[i].key, DIRECTED[i].known,
              DIRECTED[i].xor_val, DIRECTED[i].st);
    end
    wait_drained();

    // Mixed traffic; hold the receiver off partway through
    idle_en = 1'b1;
    refill_pool();
    run_mixed(80);
    hold_req = 1'b1;
    run_mixed(170);

    // Fill every entry, then push new keys against the full store
    while (set_live < CAPACITY) send_op(mxs_pkg::MODE_INSERT, $urandom);
    for (int k = 0; k < 4; k++) begin
      send_op(mxs_pkg::MODE_INSERT, $urandom);
      send_op(mxs_pkg::MODE_QUERY, $urandom);
    end
    send_op(mxs_pkg::MODE_INSERT, set_vals[$urandom_range(0, CAPACITY - 1)]);

    // Saturate one copy count
    slot = $urandom_range(0, CAPACITY - 1);
    while (set_cnts[slot] < mxs_pkg::COUNT_MAX) send_op(mxs_pkg::MODE_INSERT, set_vals[slot]);
    send_op(mxs_pkg::MODE_INSERT, set_vals[slot]);
    send_op(mxs_pkg::MODE_INSERT, set_vals[slot]);
    send_op(mxs_pkg::MODE_DELETE, set_vals[slot]);
    send_op(mxs_pkg::MODE_INSERT, set_vals[slot]);
    send_op(mxs_pkg::MODE_INSERT, set_vals[slot]);

    // Drain every copy, with queries along the way
    for (int i = 0; i < CAPACITY; i++) begin
      while (set_cnts[i] != '0) begin
        send_op(mxs_pkg::MODE_DELETE, set_vals[i]);
        if ($urandom_range(0, 7) == 0) send_op(mxs_pkg::MODE_QUERY, $urandom);
      end
    end
    send_op(mxs_pkg::MODE_QUERY, $urandom);
    send_op(mxs_pkg::MODE_DELETE, $urandom);
    wait_drained();

    // Back-to-back stretch, then idling again until the target count
    idle_en = 1'b0;
    refill_pool();
    run_mixed(40);
    idle_en = 1'b1;
    run_mixed(20);
    while (sent_cnt < ITEM_TARGET) run_mixed(1);
    wait_drained();

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (error_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
